FILE: design/battery_voltage_gauge_core_assert.svh
// assertion helpers for the battery gauge core
`ifndef BATTERY_VOLTAGE_GAUGE_CORE_ASSERT_SVH
`define BATTERY_VOLTAGE_GAUGE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define BVG_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define BVG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: design/bvg_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bvg_pkg;

   localparam int RAW_W     = 10;
   localparam int MV_W      = 15;
   localparam int PCT_W     = 7;
   localparam int CSR_IDX_W = 1;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 22;
   localparam int MUL_B_W = 14;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic [MUL_B_W-1:0] ADC_SCALE  = 14'd5000;
   localparam int                 ADC_SHIFT  = 10;
   localparam logic [MUL_B_W-1:0] DIV_SCALE  = 14'd563;
   // ceil(2^20 / 100), overestimates by at most one for 22-bit dividends
   localparam logic [MUL_B_W-1:0] RECIP_100  = 14'd10486;
   localparam int                 RECIP_SHIFT = 20;
   localparam logic [MUL_B_W-1:0] PCT_SCALE  = 14'd100;
   localparam logic [PCT_W-1:0]   PCT_FULL   = 7'd100;
   localparam int                 FILTER_SHIFT = 3;

   localparam int DIV_STEPS = PCT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   localparam logic [MV_W-1:0] EMPTY_RESET = 15'd6000;
   localparam logic [MV_W-1:0] FULL_RESET  = 15'd9000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_EMPTY = 1'b0,
      CSR_FULL  = 1'b1
   } csr_index_type;

endpackage

`default_nettype wire

FILE: design/bvg_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bvg_req_if;
   logic                        valid;
   logic                        ready;
   logic [bvg_pkg::RAW_W-1:0]   raw_sample;

   modport source (output valid, output raw_sample, input ready);
   modport sink (input valid, input raw_sample, output ready);
endinterface

interface bvg_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [bvg_pkg::MV_W-1:0]    filtered_mv;
   logic [bvg_pkg::PCT_W-1:0]   charge_percent;

   modport source (output valid, output filtered_mv, output charge_percent, input ready);
   modport sink (input valid, input filtered_mv, input charge_percent, output ready);
endinterface

interface bvg_csr_if;
   logic                           valid;
   logic                           ready;
   logic [bvg_pkg::CSR_IDX_W-1:0]  index;
   logic [bvg_pkg::MV_W-1:0]       data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/battery_voltage_gauge_core.sv
// Battery gauge: each 10-bit converter sample is scaled to millivolts, smoothed by a
// one-eighth moving average (the first sample after reset loads it directly) and
// returned with a linear charge percentage between the empty and full thresholds.
// One sample is handled at a time under a small sequencer around one shared
// 22x14 multiplier and a one-bit-per-cycle compare-subtract divider. From the
// transfer of a sample the sequencer runs S_ADC, S_SCALE, S_RECIP, S_FIX, S_FILTER
// and S_PCT, then goes to S_DONE when the filtered value lies at or outside the
// thresholds, else first through the 7-step division in S_DIV; the result is offered
// in the same cycle that the block is ready again and a waiting result holds the
// sequencer in its last step. Threshold writes are accepted in every cycle.
`timescale 1ns / 1ps
`default_nettype none

`include "battery_voltage_gauge_core_assert.svh"

module battery_voltage_gauge_core (
   input  wire logic  clock,
   input  wire logic  reset,
   bvg_req_if.sink    req_ch,
   bvg_rsp_if.source  rsp_ch,
   bvg_csr_if.sink    csr_ch
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_ADC,
      S_SCALE,
      S_RECIP,
      S_FIX,
      S_FILTER,
      S_PCT,
      S_DIV,
      S_DONE
   } state_type;

   state_type                              state_ff, state_in;
   logic [bvg_pkg::RAW_W-1:0]              raw_ff, raw_in;
   logic [bvg_pkg::PROD_W-1:0]             prod_ff, prod_in;
   logic [bvg_pkg::MUL_A_W-1:0]            x_ff, x_in;
   logic [bvg_pkg::MV_W-1:0]               q0_ff, q0_in;
   logic [bvg_pkg::MV_W-1:0]               filter_ff, filter_in;
   logic                                   primed_ff, primed_in;
   logic [bvg_pkg::MV_W-1:0]               span_ff, span_in;
   logic [bvg_pkg::PCT_W-1:0]              pct_ff, pct_in;
   logic [bvg_pkg::DIV_CNT_W-1:0]          cnt_ff, cnt_in;
   logic                                   rsp_valid_ff, rsp_valid_in;
   logic [bvg_pkg::MV_W-1:0]               rsp_mv_ff, rsp_mv_in;
   logic [bvg_pkg::PCT_W-1:0]              rsp_pct_ff, rsp_pct_in;
   logic [bvg_pkg::MV_W-1:0]               empty_ff, empty_in;
   logic [bvg_pkg::MV_W-1:0]               full_ff, full_in;

   logic [bvg_pkg::MUL_A_W-1:0]            mul_a;
   logic [bvg_pkg::MUL_B_W-1:0]            mul_b;
   logic [bvg_pkg::PROD_W-1:0]             mul_p;
   logic [bvg_pkg::MV_W-1:0]               scaled_mv;
   logic [bvg_pkg::MV_W:0]                 filter_sum;
   logic [bvg_pkg::MUL_A_W-1:0]            rem;
   logic [bvg_pkg::MUL_A_W-1:0]            trial;
   logic                                   req_xfer;
   logic                                   slot_free;

   assign req_xfer  = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign csr_ch.ready          = 1'b1;
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.filtered_mv    = rsp_mv_ff;
   assign rsp_ch.charge_percent = rsp_pct_ff;

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff)
         S_ADC: begin
            mul_a = {{(bvg_pkg::MUL_A_W - bvg_pkg::RAW_W){1'b0}}, raw_ff};
            mul_b = bvg_pkg::ADC_SCALE;
         end
         S_SCALE: begin
            mul_a = {{(bvg_pkg::MUL_A_W - 13){1'b0}}, prod_ff[bvg_pkg::ADC_SHIFT +: 13]};
            mul_b = bvg_pkg::DIV_SCALE;
         end
         S_RECIP: begin
            mul_a = prod_ff[bvg_pkg::MUL_A_W-1:0];
            mul_b = bvg_pkg::RECIP_100;
         end
         S_FIX: begin
            mul_a = {{(bvg_pkg::MUL_A_W - bvg_pkg::MV_W){1'b0}},
                     prod_ff[bvg_pkg::RECIP_SHIFT +: bvg_pkg::MV_W]};
            mul_b = bvg_pkg::PCT_SCALE;
         end
         S_PCT: begin
            mul_a = {{(bvg_pkg::MUL_A_W - bvg_pkg::MV_W){1'b0}}, filter_ff - empty_ff};
            mul_b = bvg_pkg::PCT_SCALE;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = {{bvg_pkg::MUL_B_W{1'b0}}, mul_a} *
                  {{bvg_pkg::MUL_A_W{1'b0}}, mul_b};

   // reciprocal estimate is at most one too high
   assign scaled_mv = (prod_ff > {{bvg_pkg::MUL_B_W{1'b0}}, x_ff}) ? q0_ff - 1'b1 : q0_ff;

   assign filter_sum = {1'b0, filter_ff} - {1'b0, filter_ff >> bvg_pkg::FILTER_SHIFT}
                       + {1'b0, scaled_mv >> bvg_pkg::FILTER_SHIFT};

   assign rem   = prod_ff[bvg_pkg::MUL_A_W-1:0];
   assign trial = {{(bvg_pkg::MUL_A_W - bvg_pkg::MV_W){1'b0}}, span_ff} << cnt_ff;

   always_comb begin
      state_in     = state_ff;
      raw_in       = raw_ff;
      prod_in      = prod_ff;
      x_in         = x_ff;
      q0_in        = q0_ff;
      filter_in    = filter_ff;
      primed_in    = primed_ff;
      span_in      = span_ff;
      pct_in       = pct_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_mv_in    = rsp_mv_ff;
      rsp_pct_in   = rsp_pct_ff;
      empty_in     = empty_ff;
      full_in      = full_ff;

      if (csr_ch.valid) begin
         unique case (bvg_pkg::csr_index_type'(csr_ch.index))
            bvg_pkg::CSR_EMPTY: empty_in = csr_ch.data;
            bvg_pkg::CSR_FULL:  full_in  = csr_ch.data;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_xfer) begin
               raw_in   = req_ch.raw_sample;
               state_in = S_ADC;
            end
         end
         S_ADC: begin
            prod_in  = mul_p;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            prod_in  = mul_p;
            state_in = S_RECIP;
         end
         S_RECIP: begin
            x_in     = prod_ff[bvg_pkg::MUL_A_W-1:0];
            prod_in  = mul_p;
            state_in = S_FIX;
         end
         S_FIX: begin
            q0_in    = prod_ff[bvg_pkg::RECIP_SHIFT +: bvg_pkg::MV_W];
            prod_in  = mul_p;
            state_in = S_FILTER;
         end
         S_FILTER: begin
            filter_in = primed_ff ? filter_sum[bvg_pkg::MV_W-1:0] : scaled_mv;
            primed_in = 1'b1;
            state_in  = S_PCT;
         end
         S_PCT: begin
            pct_in = '0;
            if (filter_ff <= empty_ff) begin
               state_in = S_DONE;
            end else if (filter_ff >= full_ff) begin
               pct_in   = bvg_pkg::PCT_FULL;
               state_in = S_DONE;
            end else begin
               prod_in  = mul_p;
               span_in  = full_ff - empty_ff;
               cnt_in   = bvg_pkg::DIV_CNT_W'(bvg_pkg::DIV_STEPS - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            if (rem >= trial) begin
               prod_in        = {{bvg_pkg::MUL_B_W{1'b0}}, rem - trial};
               pct_in[cnt_ff] = 1'b1;
            end
            if (cnt_ff == '0) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_mv_in    = filter_ff;
               rsp_pct_in   = pct_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         primed_ff    <= 1'b0;
         filter_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         empty_ff     <= bvg_pkg::EMPTY_RESET;
         full_ff      <= bvg_pkg::FULL_RESET;
      end else begin
         state_ff     <= state_in;
         primed_ff    <= primed_in;
         filter_ff    <= filter_in;
         rsp_valid_ff <= rsp_valid_in;
         empty_ff     <= empty_in;
         full_ff      <= full_in;
      end
      raw_ff     <= raw_in;
      prod_ff    <= prod_in;
      x_ff       <= x_in;
      q0_ff      <= q0_in;
      span_ff    <= span_in;
      pct_ff     <= pct_in;
      cnt_ff     <= cnt_in;
      rsp_mv_ff  <= rsp_mv_in;
      rsp_pct_ff <= rsp_pct_in;
   end

   `BVG_ASSERT_NEXT(a_busy_after_xfer, clock, reset, req_xfer, !req_ch.ready,
      "input accepted while a sample is still in work")
   `BVG_ASSERT_SAME(a_pct_in_range, clock, reset, rsp_valid_ff, rsp_pct_ff <= bvg_pkg::PCT_FULL,
      "charge percentage above full scale")
   `BVG_ASSERT_SAME(a_primed_on_result, clock, reset, rsp_valid_ff, primed_ff,
      "result offered before the filter was loaded")
   `BVG_ASSERT_NEXT(a_div_remainder, clock, reset, (state_ff == S_DIV) && (cnt_ff == '0),
      (rem < {{(bvg_pkg::MUL_A_W - bvg_pkg::MV_W){1'b0}}, span_ff}),
      "division remainder not below the threshold span")

endmodule

`default_nettype wire
